// ===== hdl/pcfrm_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfrm_pkg
// Shared types and constants of the pausable clock frame rate monitor.
// ----------------------------------------------------------------------------
package pcfrm_pkg;

    localparam int TIME_W      = 64;
    localparam int TPS_W       = 40;
    localparam int FPS_W       = 16;
    localparam int AVG_FPS_W   = 32;
    localparam int MS_W        = 26;
    localparam int FPS_TOTAL_W = 48;
    localparam int MS_TOTAL_W  = 58;
    localparam int WIN_CNT_W   = 32;

    // Shared divider: 64-bit dividend, 32-bit divisor, 32-bit quotient
    localparam int DIV_W       = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 312;
    localparam int OUT_TUSER_W = 2;

    // 1000 ms in 16.16 fixed point
    localparam logic [MS_W:0]      MS_ONE_SECOND_Q16 = 27'd65536000;
    localparam logic [TPS_W-1:0]   TPS_RESET         = 40'd10000000;
    localparam logic [FPS_W-1:0]   FPS_SAT           = 16'hFFFF;
    localparam logic [WIN_CNT_W-1:0] WIN_SAT         = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_START = 2'd2,
        CMD_RESET = 2'd3
    } cmd_t;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_EXEC     = 10'b00_0000_0010,
        S_GAME     = 10'b00_0000_0100,
        S_CHECK    = 10'b00_0000_1000,
        S_DIV_MS   = 10'b00_0001_0000,
        S_CLOSE    = 10'b00_0010_0000,
        S_AVG      = 10'b00_0100_0000,
        S_DIV_AVGF = 10'b00_1000_0000,
        S_DIV_AVGM = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } state_t;

endpackage

// ===== hdl/pausable_clock_frame_rate_monitor.sv =====
// ----------------------------------------------------------------------------
// pausable_clock_frame_rate_monitor
// Pausable game clock with windowed frame rate statistics.
// ----------------------------------------------------------------------------
// Each request carries a command in s_axis_tuser (frame tick, stop, start,
// reset) and a free-running counter stamp in s_axis_tdata, and yields exactly
// one result on the m_axis side. The block keeps game time (stamp minus base
// minus total time stopped) and counts frames; once ticks_per_second of game
// time has passed since the open window began, the frame count is latched as
// fps and 1000/fps ms is formed in 16.16, and min, max and averages are
// refreshed. All divisions run through one shared restoring divider that
// retires one quotient bit per clock. A stop, start or reset request, or a
// frame tick while paused, passes the execution and game-time steps, and its
// result enters the output register once that is free; a running frame tick
// also passes the window check, and one that closes a window adds three
// divisions (ms per frame, average fps, average ms) in turn. The block
// takes one request at a time: tready is high only while the sequencer is
// idle. A finished result waits in the output register while the next request
// is accepted. ticks_per_second is written through tps_wr_en / tps_wr_data and
// must only change while the block is idle.
// ----------------------------------------------------------------------------
module pausable_clock_frame_rate_monitor
    import pcfrm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration: ticks_per_second
    input  logic                   tps_wr_en,
    input  logic [TPS_W-1:0]       tps_wr_data,
    // request channel
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [63:0] time_now
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // [1:0] command
    // result channel
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [63:0] delta_ticks, [127:64] game_ticks, [143:128] fps,
    // [159:144] min_fps, [175:160] max_fps, [207:176] avg_fps,
    // [233:208] ms_per_frame, [259:234] min_ms, [285:260] max_ms,
    // [311:286] avg_ms
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] clock_stopped, [1] window_closed
    output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                  state_reg,      state_next;
    logic [TPS_W-1:0]        tps_reg,        tps_next;

    logic [TIME_W-1:0]       base_reg,       base_next;
    logic [TIME_W-1:0]       prev_reg,       prev_next;
    logic [TIME_W-1:0]       stop_reg,       stop_next;
    logic [TIME_W-1:0]       total_reg,      total_next;
    logic                    paused_reg,     paused_next;
    logic [TIME_W-1:0]       wstart_reg,     wstart_next;
    logic [FPS_W-1:0]        frame_cnt_reg,  frame_cnt_next;
    logic [FPS_W-1:0]        last_fps_reg,   last_fps_next;
    logic [FPS_W-1:0]        low_fps_reg,    low_fps_next;
    logic [FPS_W-1:0]        high_fps_reg,   high_fps_next;
    logic [FPS_TOTAL_W-1:0]  fps_total_reg,  fps_total_next;
    logic [WIN_CNT_W-1:0]    windows_reg,    windows_next;
    logic [MS_W-1:0]         last_ms_reg,    last_ms_next;
    logic [MS_W-1:0]         low_ms_reg,     low_ms_next;
    logic [MS_W-1:0]         high_ms_reg,    high_ms_next;
    logic [MS_TOTAL_W-1:0]   ms_total_reg,   ms_total_next;
    logic [AVG_FPS_W-1:0]    avg_fps_reg,    avg_fps_next;
    logic [MS_W-1:0]         avg_ms_reg,     avg_ms_next;

    // request payload and per-request working values
    cmd_t                    cmd_reg,        cmd_next;
    logic [TIME_W-1:0]       now_reg,        now_next;
    logic [TIME_W-1:0]       delta_reg,      delta_next;
    logic [TIME_W-1:0]       game_reg,       game_next;
    logic                    closed_reg,     closed_next;

    // shared divider
    logic [DIV_W-1:0]        div_rem_reg,    div_rem_next;
    logic [DIV_W-1:0]        div_quo_reg,    div_quo_next;
    logic [DIV_W-1:0]        div_den_reg,    div_den_next;
    logic [DIV_CNT_W-1:0]    div_cnt_reg,    div_cnt_next;

    // result register
    logic                    out_valid_reg,  out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg,   out_data_next;
    logic [OUT_TUSER_W-1:0]  out_user_reg,   out_user_next;

    // ------------------------------------------------------------------
    // Divider datapath: one trial subtraction per clock
    // ------------------------------------------------------------------
    logic [DIV_W:0]          div_trial;
    logic [DIV_W+1:0]        div_diff;
    logic                    div_take;
    logic [DIV_W-1:0]        div_rem_step;
    logic [DIV_W-1:0]        div_quo_step;
    logic                    div_load;
    logic [2*DIV_W-1:0]      div_dividend;
    logic [DIV_W-1:0]        div_divisor;

    assign div_trial    = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_diff     = {1'b0, div_trial} - {2'b00, div_den_reg};
    assign div_take     = ~div_diff[DIV_W+1];
    assign div_rem_step = div_take ? div_diff[DIV_W-1:0] : div_trial[DIV_W-1:0];
    assign div_quo_step = {div_quo_reg[DIV_W-2:0], div_take};

    // ------------------------------------------------------------------
    // Working values
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]       game_src;
    logic [TIME_W:0]         win_diff;
    logic                    win_close;
    logic                    out_free;
    logic [MS_W-1:0]         ms_new;
    logic [WIN_CNT_W-1:0]    half_win;

    assign game_src  = paused_reg ? stop_reg : now_reg;
    // game time behind window start never closes a window
    assign win_diff  = {1'b0, game_reg} - {1'b0, wstart_reg};
    assign win_close = ~win_diff[TIME_W] &&
                       (win_diff[TIME_W-1:0] >= {{(TIME_W-TPS_W){1'b0}}, tps_reg});
    assign out_free  = ~out_valid_reg | m_axis_tready;
    assign ms_new    = div_quo_step[MS_W-1:0];
    assign half_win  = windows_reg >> 1;

    assign s_axis_tready = (state_reg == S_IDLE);

    // ------------------------------------------------------------------
    // Sequencer and next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        tps_next       = tps_wr_en ? tps_wr_data : tps_reg;
        base_next      = base_reg;
        prev_next      = prev_reg;
        stop_next      = stop_reg;
        total_next     = total_reg;
        paused_next    = paused_reg;
        wstart_next    = wstart_reg;
        frame_cnt_next = frame_cnt_reg;
        last_fps_next  = last_fps_reg;
        low_fps_next   = low_fps_reg;
        high_fps_next  = high_fps_reg;
        fps_total_next = fps_total_reg;
        windows_next   = windows_reg;
        last_ms_next   = last_ms_reg;
        low_ms_next    = low_ms_reg;
        high_ms_next   = high_ms_reg;
        ms_total_next  = ms_total_reg;
        avg_fps_next   = avg_fps_reg;
        avg_ms_next    = avg_ms_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        delta_next     = delta_reg;
        game_next      = game_reg;
        closed_next    = closed_reg;
        div_load       = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = cmd_t'(s_axis_tuser);
                    now_next   = s_axis_tdata;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                delta_next  = '0;
                closed_next = 1'b0;
                state_next  = S_GAME;
                unique case (cmd_reg)
                    CMD_TICK:
                    begin
                        if (!paused_reg)
                        begin
                            delta_next = now_reg - prev_reg;
                            prev_next  = now_reg;
                            if (frame_cnt_reg != FPS_SAT)
                            begin
                                frame_cnt_next = frame_cnt_reg + 1'b1;
                            end
                        end
                    end
                    CMD_STOP:
                    begin
                        if (!paused_reg)
                        begin
                            stop_next   = now_reg;
                            paused_next = 1'b1;
                        end
                    end
                    CMD_START:
                    begin
                        if (paused_reg)
                        begin
                            total_next  = total_reg + (now_reg - stop_reg);
                            prev_next   = now_reg;
                            paused_next = 1'b0;
                        end
                    end
                    CMD_RESET:
                    begin
                        base_next      = now_reg;
                        prev_next      = now_reg;
                        stop_next      = '0;
                        total_next     = '0;
                        paused_next    = 1'b0;
                        wstart_next    = '0;
                        frame_cnt_next = '0;
                        last_fps_next  = '0;
                        low_fps_next   = '0;
                        high_fps_next  = '0;
                        fps_total_next = '0;
                        windows_next   = '0;
                        last_ms_next   = '0;
                        low_ms_next    = '0;
                        high_ms_next   = '0;
                        ms_total_next  = '0;
                        avg_fps_next   = '0;
                        avg_ms_next    = '0;
                    end
                    default:
                    begin
                        state_next = S_GAME;
                    end
                endcase
            end

            S_GAME:
            begin
                game_next = game_src - base_reg - total_reg;
                if (cmd_reg == CMD_TICK && !paused_reg)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_CHECK:
            begin
                if (win_close)
                begin
                    // round half up: (1000 ms + f/2) / f, f is at least one
                    div_load     = 1'b1;
                    div_dividend = {{(2*DIV_W-MS_W-1){1'b0}},
                                    MS_ONE_SECOND_Q16 +
                                    {{(MS_W+1-FPS_W){1'b0}}, frame_cnt_reg >> 1}};
                    div_divisor  = {{(DIV_W-FPS_W){1'b0}}, frame_cnt_reg};
                    state_next   = S_DIV_MS;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_DIV_MS:
            begin
                if (div_cnt_reg == '0)
                begin
                    last_ms_next = ms_new;
                    state_next   = S_CLOSE;
                end
            end

            S_CLOSE:
            begin
                last_fps_next = frame_cnt_reg;
                if (windows_reg == '0)
                begin
                    low_fps_next   = frame_cnt_reg;
                    high_fps_next  = frame_cnt_reg;
                    low_ms_next    = last_ms_reg;
                    high_ms_next   = last_ms_reg;
                    fps_total_next = {{(FPS_TOTAL_W-FPS_W){1'b0}}, frame_cnt_reg};
                    ms_total_next  = {{(MS_TOTAL_W-MS_W){1'b0}}, last_ms_reg};
                    windows_next   = {{(WIN_CNT_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    if (frame_cnt_reg < low_fps_reg)  low_fps_next  = frame_cnt_reg;
                    if (frame_cnt_reg > high_fps_reg) high_fps_next = frame_cnt_reg;
                    if (last_ms_reg < low_ms_reg)     low_ms_next   = last_ms_reg;
                    if (last_ms_reg > high_ms_reg)    high_ms_next  = last_ms_reg;
                    // hold the sums once the window count saturates
                    if (windows_reg != WIN_SAT)
                    begin
                        fps_total_next = fps_total_reg +
                                         {{(FPS_TOTAL_W-FPS_W){1'b0}}, frame_cnt_reg};
                        ms_total_next  = ms_total_reg +
                                         {{(MS_TOTAL_W-MS_W){1'b0}}, last_ms_reg};
                        windows_next   = windows_reg + 1'b1;
                    end
                end
                frame_cnt_next = '0;
                wstart_next    = wstart_reg + {{(TIME_W-TPS_W){1'b0}}, tps_reg};
                closed_next    = 1'b1;
                state_next     = S_AVG;
            end

            S_AVG:
            begin
                div_load     = 1'b1;
                div_dividend = {fps_total_reg, {(2*DIV_W-FPS_TOTAL_W){1'b0}}} +
                               {{DIV_W{1'b0}}, half_win};
                div_divisor  = windows_reg;
                state_next   = S_DIV_AVGF;
            end

            S_DIV_AVGF:
            begin
                if (div_cnt_reg == '0)
                begin
                    avg_fps_next = div_quo_step;
                    div_load     = 1'b1;
                    div_dividend = {{(2*DIV_W-MS_TOTAL_W){1'b0}}, ms_total_reg} +
                                   {{DIV_W{1'b0}}, half_win};
                    div_divisor  = windows_reg;
                    state_next   = S_DIV_AVGM;
                end
            end

            S_DIV_AVGM:
            begin
                if (div_cnt_reg == '0)
                begin
                    avg_ms_next = div_quo_step[MS_W-1:0];
                    state_next  = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {avg_ms_reg, high_ms_reg, low_ms_reg, last_ms_reg,
                                      avg_fps_reg, high_fps_reg, low_fps_reg,
                                      last_fps_reg, game_reg, delta_reg};
                    out_user_next  = {closed_reg, paused_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shared divider: load a new division or retire one quotient bit
        div_rem_next = div_rem_reg;
        div_quo_next = div_quo_reg;
        div_den_next = div_den_reg;
        div_cnt_next = div_cnt_reg;
        if (div_load)
        begin
            // the quotient fits in 32 bits, so the upper half is below the divisor
            div_rem_next = div_dividend[2*DIV_W-1:DIV_W];
            div_quo_next = div_dividend[DIV_W-1:0];
            div_den_next = div_divisor;
            div_cnt_next = DIV_CNT_W'(DIV_W - 1);
        end
        else if (state_reg == S_DIV_MS || state_reg == S_DIV_AVGF ||
                 state_reg == S_DIV_AVGM)
        begin
            div_rem_next = div_rem_step;
            div_quo_next = div_quo_step;
            div_cnt_next = div_cnt_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control and clock state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tps_reg       <= TPS_RESET;
            base_reg      <= '0;
            prev_reg      <= '0;
            stop_reg      <= '0;
            total_reg     <= '0;
            paused_reg    <= 1'b0;
            wstart_reg    <= '0;
            frame_cnt_reg <= '0;
            last_fps_reg  <= '0;
            low_fps_reg   <= '0;
            high_fps_reg  <= '0;
            fps_total_reg <= '0;
            windows_reg   <= '0;
            last_ms_reg   <= '0;
            low_ms_reg    <= '0;
            high_ms_reg   <= '0;
            ms_total_reg  <= '0;
            avg_fps_reg   <= '0;
            avg_ms_reg    <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tps_reg       <= tps_next;
            base_reg      <= base_next;
            prev_reg      <= prev_next;
            stop_reg      <= stop_next;
            total_reg     <= total_next;
            paused_reg    <= paused_next;
            wstart_reg    <= wstart_next;
            frame_cnt_reg <= frame_cnt_next;
            last_fps_reg  <= last_fps_next;
            low_fps_reg   <= low_fps_next;
            high_fps_reg  <= high_fps_next;
            fps_total_reg <= fps_total_next;
            windows_reg   <= windows_next;
            last_ms_reg   <= last_ms_next;
            low_ms_reg    <= low_ms_next;
            high_ms_reg   <= high_ms_next;
            ms_total_reg  <= ms_total_next;
            avg_fps_reg   <= avg_fps_next;
            avg_ms_reg    <= avg_ms_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: no reset needed
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        now_reg      <= now_next;
        delta_reg    <= delta_next;
        game_reg     <= game_next;
        closed_reg   <= closed_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // a request always starts its execution step on the next clock
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_EXEC))
        else $error("accepted request did not enter execution");

    // the remainder stays below the divisor throughout each division
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_MS || state_reg == S_DIV_AVGF ||
         state_reg == S_DIV_AVGM) |-> (div_rem_reg < div_den_reg))
        else $error("divider remainder out of range");

    // once a window has closed, minimum never exceeds maximum
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (windows_reg != '0) |-> (low_fps_reg <= high_fps_reg &&
                                 low_ms_reg <= high_ms_reg))
        else $error("minimum above maximum");

    // a window can only close while the clock runs
    a_close_running: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> !m_axis_tuser[0])
        else $error("window closed while clock stopped");

endmodule

// ===== bench/tb_pausable_clock_frame_rate_monitor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pausable_clock_frame_rate_monitor
// Self-checking bench for the pausable clock frame rate monitor.
// ----------------------------------------------------------------------------
// An initial block writes ticks_per_second between phases, while the block is
// idle, and fills a queue of stamped commands. A clocked driver offers them in
// bursts with random gaps. A clocked monitor predicts each accepted request
// against its own copy of the game clock and frame statistics, and compares
// every result field by field with the oldest expectation. The receiver
// stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_pausable_clock_frame_rate_monitor;
    import pcfrm_pkg::*;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] stamp;
    } clock_request_t;

    typedef struct packed {
        logic [63:0] delta;
        logic [63:0] game;
        logic [15:0] fps;
        logic [15:0] min_fps;
        logic [15:0] max_fps;
        logic [31:0] avg_fps;
        logic [25:0] ms;
        logic [25:0] min_ms;
        logic [25:0] max_ms;
        logic [25:0] avg_ms;
        logic        stopped;
        logic        closed;
    } frame_report_t;

    localparam logic [TPS_W-1:0] TPS_MAX = {TPS_W{1'b1}};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   tps_wr_en = 1'b0;
    logic [TPS_W-1:0]       tps_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [63:0] time_now
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // [1:0] command
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [63:0] delta_ticks, [127:64] game_ticks, [143:128] fps,
    // [159:144] min_fps, [175:160] max_fps, [207:176] avg_fps,
    // [233:208] ms_per_frame, [259:234] min_ms, [285:260] max_ms,
    // [311:286] avg_ms
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] clock_stopped, [1] window_closed
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    pausable_clock_frame_rate_monitor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .tps_wr_en     (tps_wr_en),
        .tps_wr_data   (tps_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    clock_request_t pending_requests[$];
    frame_report_t  expected_reports[$];
    int             mismatches = 0;
    int             reports_seen = 0;
    bit             rush = 1'b0;          // no gaps, no stalls: long tick runs
    bit             hold_request = 1'b0;  // arm the one long receiver hold-off

    // ------------------------------------------------------------------
    // Predictor state: game clock and window statistics
    // ------------------------------------------------------------------
    logic [TPS_W-1:0]     tps_q = TPS_RESET;
    logic [63:0]          origin = '0;        // base of game time
    logic [63:0]          last_stamp = '0;    // stamp of the previous tick
    logic [63:0]          halt_stamp = '0;
    logic [63:0]          halted_total = '0;
    logic                 halted = 1'b0;
    logic [63:0]          win_open = '0;      // game time the open window began
    logic [15:0]          frames = '0;
    logic [15:0]          cur_fps = '0;
    logic [15:0]          lo_fps = '0;
    logic [15:0]          hi_fps = '0;
    logic [47:0]          fps_sum = '0;
    logic [WIN_CNT_W-1:0] win_count = '0;
    logic [31:0]          cur_ms = '0;
    logic [31:0]          lo_ms = '0;
    logic [31:0]          hi_ms = '0;
    logic [63:0]          ms_sum = '0;

    function automatic logic [63:0] game_now(input logic [63:0] now);
        return (halted ? halt_stamp : now) - origin - halted_total;
    endfunction

    function automatic void clear_frame_stats();
        win_open  = '0;
        frames    = '0;
        cur_fps   = '0;
        lo_fps    = '0;
        hi_fps    = '0;
        fps_sum   = '0;
        win_count = '0;
        cur_ms    = '0;
        lo_ms     = '0;
        hi_ms     = '0;
        ms_sum    = '0;
    endfunction

    // Advance the game clock by one command and form the result it yields
    task automatic advance_clock(input cmd_t cmd, input logic [63:0] now,
                                 output frame_report_t rep);
        logic [63:0] game;
        logic [63:0] ms_q;
        logic [63:0] n;
        logic [63:0] avg_f;
        logic [63:0] avg_m;
        logic        closed;
        rep    = '0;
        closed = 1'b0;
        avg_f  = '0;
        avg_m  = '0;
        case (cmd)
            CMD_TICK:
            begin
                if (!halted)
                begin
                    rep.delta  = now - last_stamp;
                    last_stamp = now;
                    if (frames != FPS_SAT)
                        frames = frames + 1'b1;
                    game = game_now(now);
                    // a window closes only while game time is not behind its start
                    if (game >= win_open && game - win_open >= 64'(tps_q))
                    begin
                        ms_q = (64'(MS_ONE_SECOND_Q16) + 64'(frames >> 1)) / 64'(frames);
                        cur_fps = frames;
                        cur_ms  = ms_q[31:0];
                        if (win_count == '0)
                        begin
                            lo_fps    = frames;
                            hi_fps    = frames;
                            lo_ms     = ms_q[31:0];
                            hi_ms     = ms_q[31:0];
                            fps_sum   = 48'(frames);
                            ms_sum    = ms_q;
                            win_count = 1;
                        end
                        else
                        begin
                            if (frames < lo_fps)     lo_fps = frames;
                            if (frames > hi_fps)     hi_fps = frames;
                            if (ms_q[31:0] < lo_ms)  lo_ms = ms_q[31:0];
                            if (ms_q[31:0] > hi_ms)  hi_ms = ms_q[31:0];
                            // sums freeze once the window count saturates
                            if (win_count != WIN_SAT)
                            begin
                                fps_sum   = fps_sum + 48'(frames);
                                ms_sum    = ms_sum + ms_q;
                                win_count = win_count + 1'b1;
                            end
                        end
                        frames   = '0;
                        win_open = win_open + 64'(tps_q);
                        closed   = 1'b1;
                    end
                end
            end
            CMD_STOP:
            begin
                if (!halted)
                begin
                    halt_stamp = now;
                    halted     = 1'b1;
                end
            end
            CMD_START:
            begin
                if (halted)
                begin
                    halted_total = halted_total + (now - halt_stamp);
                    last_stamp   = now;
                    halted       = 1'b0;
                end
            end
            default:
            begin
                origin       = now;
                last_stamp   = now;
                halt_stamp   = '0;
                halted_total = '0;
                halted       = 1'b0;
                clear_frame_stats();
            end
        endcase

        if (win_count != '0)
        begin
            n     = 64'(win_count);
            avg_f = ((64'(fps_sum) << 16) + (n >> 1)) / n;
            avg_m = (ms_sum + (n >> 1)) / n;
        end

        rep.game    = game_now(now);
        rep.fps     = cur_fps;
        rep.min_fps = lo_fps;
        rep.max_fps = hi_fps;
        rep.avg_fps = avg_f[31:0];
        rep.ms      = cur_ms[25:0];
        rep.min_ms  = lo_ms[25:0];
        rep.max_ms  = hi_ms[25:0];
        rep.avg_ms  = avg_m[25:0];
        rep.stopped = halted;
        rep.closed  = closed;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer queued requests in bursts with random gaps
    // ------------------------------------------------------------------
    clock_request_t next_request;
    int             burst_left = 0;
    int             gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left != 0 && !rush)
            begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                next_request   = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_request.stamp;
                s_axis_tuser  <= next_request.cmd;
                if (rush)
                begin
                    gap_left <= 0;
                end
                else if (burst_left <= 1)
                begin
                    // long bursts now and then leave stretches with no idling
                    burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
                                                              : $urandom_range(1, 10);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a changing pattern, hold off once for long
    // ------------------------------------------------------------------
    logic [31:0] stall_clock = '0;
    int          hold_left = 0;
    bit          held_off = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall_clock <= stall_clock + 1;
            if (hold_left != 0)
            begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_request && !held_off)
            begin
                // sender keeps offering meanwhile, so the block backs up
                held_off      <= 1'b1;
                hold_left     <= 600;
                m_axis_tready <= 1'b0;
            end
            else if (rush)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                case (stall_clock[9:8])
                    2'd0:    m_axis_tready <= 1'b1;
                    2'd1:    m_axis_tready <= $urandom_range(0, 1);
                    2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (stall_clock[2:0] < 3'd5);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results, then predict newly accepted requests
    // ------------------------------------------------------------------
    frame_report_t seen_report;
    frame_report_t due_report;
    frame_report_t fresh_report;

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_report.delta   = m_axis_tdata[63:0];
                seen_report.game    = m_axis_tdata[127:64];
                seen_report.fps     = m_axis_tdata[143:128];
                seen_report.min_fps = m_axis_tdata[159:144];
                seen_report.max_fps = m_axis_tdata[175:160];
                seen_report.avg_fps = m_axis_tdata[207:176];
                seen_report.ms      = m_axis_tdata[233:208];
                seen_report.min_ms  = m_axis_tdata[259:234];
                seen_report.max_ms  = m_axis_tdata[285:260];
                seen_report.avg_ms  = m_axis_tdata[311:286];
                seen_report.stopped = m_axis_tuser[0];
                seen_report.closed  = m_axis_tuser[1];
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, seen_report);
                    mismatches++;
                end
                else
                begin
                    due_report = expected_reports.pop_front();
                    check_field("delta_ticks",   due_report.delta,   seen_report.delta);
                    check_field("game_ticks",    due_report.game,    seen_report.game);
                    check_field("fps",           due_report.fps,     seen_report.fps);
                    check_field("min_fps",       due_report.min_fps, seen_report.min_fps);
                    check_field("max_fps",       due_report.max_fps, seen_report.max_fps);
                    check_field("avg_fps",       due_report.avg_fps, seen_report.avg_fps);
                    check_field("ms_per_frame",  due_report.ms,      seen_report.ms);
                    check_field("min_ms",        due_report.min_ms,  seen_report.min_ms);
                    check_field("max_ms",        due_report.max_ms,  seen_report.max_ms);
                    check_field("avg_ms",        due_report.avg_ms,  seen_report.avg_ms);
                    check_field("clock_stopped", due_report.stopped, seen_report.stopped);
                    check_field("window_closed", due_report.closed,  seen_report.closed);
                end
                reports_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_clock(cmd_t'(s_axis_tuser), s_axis_tdata, fresh_report);
                expected_reports.push_back(fresh_report);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_request(input cmd_t cmd, input logic [63:0] stamp);
        clock_request_t req;
        req.cmd   = cmd;
        req.stamp = stamp;
        pending_requests.push_back(req);
    endfunction

    // Hold until every request is sent and answered, then let the block settle
    task automatic settle();
        while (pending_requests.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tps(input logic [TPS_W-1:0] value);
        @(posedge clk);
        tps_wr_en   <= 1'b1;
        tps_wr_data <= value;
        tps_q        = value;
        @(posedge clk);
        tps_wr_en   <= 1'b0;
    endtask

    // Mostly well-formed play: a reset, then ticks on a rising counter with
    // pauses, occasional resets and a little noise with wild stamps.
    task automatic queue_random_traffic(input int count, input logic [TPS_W-1:0] rate);
        logic [63:0] stamp;
        logic [63:0] step;
        bit          paused_gen;
        int          roll;
        int          k;
        stamp      = {$urandom, $urandom};
        paused_gen = 1'b0;
        queue_request(CMD_RESET, stamp);
        for (k = 1; k < count; k++)
        begin
            roll  = $urandom_range(0, 99);
            step  = (64'(rate) * $urandom_range(1, 30)) / 100 + $urandom_range(0, 3);
            stamp = stamp + step;
            if (roll < 3)
            begin
                queue_request(cmd_t'($urandom_range(0, 3)), {$urandom, $urandom});
            end
            else if (roll < 5)
            begin
                queue_request(CMD_RESET, stamp);
                paused_gen = 1'b0;
            end
            else if (roll < 12)
            begin
                queue_request(paused_gen ? CMD_START : CMD_STOP, stamp);
                paused_gen = !paused_gen;
            end
            else
            begin
                queue_request(CMD_TICK, stamp);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic [TPS_W-1:0] random_rates[6];
    int               p;
    int               t;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Default rate: a second of counter ticks closes the first window
        queue_request(CMD_TICK, 64'd0);
        queue_request(CMD_TICK, 64'd10_000_000);
        settle();

        // Short windows: pause handling, ignored repeats, stamps going back
        write_tps(40'd100);
        queue_request(CMD_RESET, 64'd0);
        queue_request(CMD_TICK,  64'd50);
        queue_request(CMD_TICK,  64'd100);
        queue_request(CMD_STOP,  64'd120);
        queue_request(CMD_STOP,  64'd130);     // already stopped: ignored
        queue_request(CMD_TICK,  64'd140);     // tick while paused
        queue_request(CMD_START, 64'd200);
        queue_request(CMD_START, 64'd210);     // already running: ignored
        queue_request(CMD_TICK,  64'd300);     // one frame in window: 1000 ms
        queue_request(CMD_TICK,  64'd250);     // game time behind window start
        queue_request(CMD_TICK,  64'd0);       // game time wraps below zero
        queue_request(CMD_RESET, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_request(CMD_TICK,  64'd5);       // stamp wraps past the top
        settle();

        // Zero rate: every running tick closes a window
        write_tps('0);
        queue_request(CMD_TICK,  64'd7);
        queue_request(CMD_STOP,  64'd9);
        queue_request(CMD_TICK,  64'd11);
        queue_request(CMD_START, 64'd20);
        queue_request(CMD_TICK,  64'd25);
        settle();

        // Widest rate
        write_tps(TPS_MAX);
        queue_request(CMD_RESET, 64'd0);
        queue_request(CMD_TICK,  64'(TPS_MAX) - 1);
        queue_request(CMD_TICK,  64'(TPS_MAX));
        queue_request(CMD_TICK,  64'hFFFF_FFFF_FFFF_FFFF);
        settle();

        // Back-to-back ticks inside one long window, then one late tick closes it
        rush = 1'b1;
        queue_request(CMD_RESET, 64'd0);
        for (t = 1; t <= 40; t++)
            queue_request(CMD_TICK, 64'(t));
        queue_request(CMD_TICK, 64'h200_0000_0000);
        settle();
        rush = 1'b0;

        // Random play over a spread of rates, the extremes among them
        random_rates[0] = 40'd37;
        random_rates[1] = 40'd1;
        random_rates[2] = 40'($urandom_range(2, 100000));
        random_rates[3] = TPS_MAX;
        random_rates[4] = '0;
        random_rates[5] = 40'd1000;
        for (p = 0; p < 6; p++)
        begin
            write_tps(random_rates[p]);
            queue_random_traffic(215, random_rates[p]);
            if (p == 0)
                hold_request = 1'b1;
            settle();
        end

        // Let the last division run out, then judge the run
        repeat (120) @(posedge clk);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
